### src/xyppm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xyppm_pkg
// Shared constants and types of the point-to-pixel mapper.
// ----------------------------------------------------------------------------
package xyppm_pkg;

	localparam int COORD_W    = 32;
	localparam int PLOT_SPAN  = 127;
	localparam int TOP_OFFSET = 32;
	localparam int PX_W       = 7;
	localparam int PY_W       = 8;

	// quotient bits: one divider stage per bit
	localparam int QW = $clog2(PLOT_SPAN + 1);
	// scaled numerator width (offset * PLOT_SPAN)
	localparam int NW = COORD_W + QW;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam int CFG_AW = 2;

	typedef enum logic [CFG_AW-1:0] {
		REG_X_MIN = 2'd0,
		REG_X_MAX = 2'd1,
		REG_Y_MIN = 2'd2,
		REG_Y_MAX = 2'd3
	} cfg_reg_t;

	// classified point handed from front to back
	typedef struct packed {
		logic               vis;
		logic               last;
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		logic [COORD_W-1:0] x_span;
		logic [COORD_W-1:0] y_span;
	} pt_t;

	// one divider stage payload
	typedef struct packed {
		logic               vis;
		logic               last;
		logic [NW-1:0]      rem_x;
		logic [NW-1:0]      rem_y;
		logic [COORD_W-1:0] x_span;
		logic [COORD_W-1:0] y_span;
		logic [QW-1:0]      q_x;
		logic [QW-1:0]      q_y;
	} div_t;

	// queue status seen by the front
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage
`default_nettype wire

### src/xy_point_to_pixel_mapper_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xy_point_to_pixel_mapper_unit
// Maps fixed-point (x, y) data points to plot pixel coordinates.
// ----------------------------------------------------------------------------
// Takes one point per clock while in_stall is low and returns one result per
// point, in order. Column = (x - x_min) * 127 / (x_max - x_min) and row =
// 32 + (y_max - y) * 127 / (y_max - y_min), both truncated; points outside
// the inclusive window, or any window whose span is not positive, come out
// with visible low and zero pixel fields. Points pass through an
// input classifier register, a four-entry queue, a multiply stage and a
// seven-stage restoring divider that resolves one quotient bit per stage for
// both axes; the queue keeps accepting input after the output stalls. Bounds
// must be written through the cfg port (index 0 x_min, 1 x_max, 2 y_min,
// 3 y_max) only while no points are in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module xy_point_to_pixel_mapper_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [xyppm_pkg::CFG_AW-1:0]        cfg_index,
	input  wire logic [xyppm_pkg::COORD_W-1:0]       cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [xyppm_pkg::COORD_W-1:0] x_value,
	input  wire logic signed [xyppm_pkg::COORD_W-1:0] y_value,
	input  wire logic                                last_point,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [xyppm_pkg::PX_W-1:0]               pixel_x,
	output logic [xyppm_pkg::PY_W-1:0]               pixel_y,
	output logic                                     visible,
	output logic                                     last_in_batch
);
	import xyppm_pkg::*;

	fifo_stat_t fifo_stat;
	logic       push, pop;
	pt_t        push_pt, pop_pt;

	xyppm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.x_value    (x_value),
		.y_value    (y_value),
		.last_point (last_point),
		.fifo_stat  (fifo_stat),
		.push       (push),
		.push_pt    (push_pt)
	);

	xyppm_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_pt (push_pt),
		.pop     (pop),
		.pop_pt  (pop_pt),
		.stat    (fifo_stat)
	);

	xyppm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.fifo_stat     (fifo_stat),
		.pop_pt        (pop_pt),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.visible       (visible),
		.last_in_batch (last_in_batch)
	);

endmodule
`default_nettype wire

### src/xyppm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xyppm_front
// Holds the window bounds, accepts points, checks bounds and forms offsets.
// ----------------------------------------------------------------------------
module xyppm_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [xyppm_pkg::CFG_AW-1:0]   cfg_index,
	input  wire logic [xyppm_pkg::COORD_W-1:0]  cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [xyppm_pkg::COORD_W-1:0] x_value,
	input  wire logic signed [xyppm_pkg::COORD_W-1:0] y_value,
	input  wire logic                           last_point,
	input  wire xyppm_pkg::fifo_stat_t          fifo_stat,
	output logic                                push,
	output xyppm_pkg::pt_t                      push_pt
);
	import xyppm_pkg::*;

	logic signed [COORD_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic                      v_s1;
	pt_t                       pt_s1;
	logic                      ok;
	logic                      load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= COORD_W'(0);
			x_max_q <= COORD_W'(1000);
			y_min_q <= COORD_W'(0);
			y_max_q <= COORD_W'(1000);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_X_MIN: x_min_q <= cfg_data;
				REG_X_MAX: x_max_q <= cfg_data;
				REG_Y_MIN: y_min_q <= cfg_data;
				REG_Y_MAX: y_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// inclusive bounds; an empty or inverted window hides everything
	assign ok = (x_max_q > x_min_q) && (y_max_q > y_min_q) &&
	            (x_value >= x_min_q) && (x_value <= x_max_q) &&
	            (y_value >= y_min_q) && (y_value <= y_max_q);

	assign push     = v_s1 && !fifo_stat.full;
	assign in_stall = v_s1 && fifo_stat.full;
	assign load     = !in_stall;
	assign push_pt  = pt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load) begin
			v_s1 <= in_valid;
		end
	end

	// offsets fit 32 unsigned bits whenever the point is inside
	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			pt_s1.vis    <= ok;
			pt_s1.last   <= last_point;
			pt_s1.dx     <= x_value - x_min_q;
			pt_s1.dy     <= y_max_q - y_value;
			pt_s1.x_span <= x_max_q - x_min_q;
			pt_s1.y_span <= y_max_q - y_min_q;
		end
	end

endmodule
`default_nettype wire

### src/xyppm_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xyppm_fifo
// Short flop queue decoupling the classifier from the scaling pipeline.
// ----------------------------------------------------------------------------
module xyppm_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire xyppm_pkg::pt_t        push_pt,
	input  wire logic                  pop,
	output xyppm_pkg::pt_t             pop_pt,
	output xyppm_pkg::fifo_stat_t      stat
);
	import xyppm_pkg::*;

	pt_t                mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               do_push, do_pop;

	assign stat.full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_pt     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_pt;
		end
	end

endmodule
`default_nettype wire

### src/xyppm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xyppm_back
// Scales offsets by the plot span and divides by the window span, one
// quotient bit per pipeline stage, then formats the pixel result.
// ----------------------------------------------------------------------------
module xyppm_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire xyppm_pkg::fifo_stat_t        fifo_stat,
	input  wire xyppm_pkg::pt_t               pop_pt,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [xyppm_pkg::PX_W-1:0]        pixel_x,
	output logic [xyppm_pkg::PY_W-1:0]        pixel_y,
	output logic                              visible,
	output logic                              last_in_batch
);
	import xyppm_pkg::*;

	logic               en;
	logic               v_s1;
	logic               vis_s1, last_s1;
	logic [NW-1:0]      num_x_s1, num_y_s1;
	logic [COORD_W-1:0] x_span_s1, y_span_s1;

	logic [QW-1:0]      div_v_s;
	div_t               div_s   [QW];
	div_t               div_nxt [QW];
	div_t               fin;
	logic [PY_W-1:0]    row;

	// whole pipeline moves together unless the result is held
	assign en  = !(div_v_s[QW-1] && out_stall);
	assign pop = en && !fifo_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			div_v_s <= '0;
		end else if (en) begin
			v_s1    <= !fifo_stat.empty;
			div_v_s <= {div_v_s[QW-2:0], v_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s1    <= pop_pt.vis;
			last_s1   <= pop_pt.last;
			num_x_s1  <= NW'(pop_pt.dx) * NW'(PLOT_SPAN);
			num_y_s1  <= NW'(pop_pt.dy) * NW'(PLOT_SPAN);
			x_span_s1 <= pop_pt.x_span;
			y_span_s1 <= pop_pt.y_span;
		end
	end

	// restoring division; offset <= span keeps the quotient within QW bits
	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int K = QW - 1 - j;
		div_t          cur;
		logic [NW-1:0] dvs_x, dvs_y;

		if (j == 0) begin : g_first
			always_comb begin
				cur.vis    = vis_s1;
				cur.last   = last_s1;
				cur.rem_x  = num_x_s1;
				cur.rem_y  = num_y_s1;
				cur.x_span = x_span_s1;
				cur.y_span = y_span_s1;
				cur.q_x    = '0;
				cur.q_y    = '0;
			end
		end else begin : g_next
			assign cur = div_s[j-1];
		end

		assign dvs_x = NW'(cur.x_span) << K;
		assign dvs_y = NW'(cur.y_span) << K;

		always_comb begin
			div_nxt[j] = cur;
			if (cur.rem_x >= dvs_x) begin
				div_nxt[j].rem_x  = cur.rem_x - dvs_x;
				div_nxt[j].q_x[K] = 1'b1;
			end
			if (cur.rem_y >= dvs_y) begin
				div_nxt[j].rem_y  = cur.rem_y - dvs_y;
				div_nxt[j].q_y[K] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[j] <= div_nxt[j];
			end
		end
	end

	assign fin           = div_s[QW-1];
	assign row           = PY_W'(TOP_OFFSET) + PY_W'(fin.q_y);
	assign out_valid     = div_v_s[QW-1];
	assign visible       = fin.vis;
	assign last_in_batch = fin.last;
	assign pixel_x       = fin.vis ? PX_W'(fin.q_x) : '0;
	assign pixel_y       = fin.vis ? row : '0;

endmodule
`default_nettype wire
